[hw/rtl/ssp_pkg.sv]
// shared types, constants and the arctangent table of the spherical spiral generator
`default_nettype none
package ssp_pkg;

    localparam int CORDIC_STEPS = 20;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 17;

    localparam logic [32:0]        TWO_PI_Q30 = 33'd6746518852;
    localparam logic [30:0]        TWO_PI_Q28 = 31'd1686629713;
    localparam logic signed [32:0] CORDIC_K   = 33'sh026DD3B6A;

    typedef struct packed {
        logic [1:0]  quad;
        logic [31:0] um;
        logic [63:0] sq;
        logic        pneg;
    } cor_side_t;

    typedef struct packed {
        logic signed [33:0] ang;
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        cor_side_t          side;
    } cor_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] n;
        logic [32:0] xmag;
        logic [32:0] ymag;
        logic        xneg;
        logic        yneg;
        logic        zneg;
        logic [31:0] um;
    } sq_t;

    typedef struct packed {
        logic [31:0]      den;
        logic [2:0][31:0] rem;
        logic [2:0][16:0] qn;
        logic [2:0]       neg;
    } dv_t;

    function automatic logic signed [33:0] atan_q30(input int step);
        logic signed [33:0] v;
        unique case (step)
            0:       v = 34'sh03243F6A8;
            1:       v = 34'sh01DAC6705;
            2:       v = 34'sh00FADBAFC;
            3:       v = 34'sh007F56EA6;
            4:       v = 34'sh003FEAB76;
            5:       v = 34'sh001FFD55B;
            6:       v = 34'sh000FFFAAA;
            7:       v = 34'sh0007FFF55;
            8:       v = 34'sh0003FFFEA;
            9:       v = 34'sh0001FFFFD;
            10:      v = 34'sd1048576;
            11:      v = 34'sd524288;
            12:      v = 34'sd262144;
            13:      v = 34'sd131072;
            14:      v = 34'sd65536;
            15:      v = 34'sd32768;
            16:      v = 34'sd16384;
            17:      v = 34'sd8192;
            18:      v = 34'sd4096;
            19:      v = 34'sd2048;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ssp_front.sv]
// front stages: angle scaling, pitch product, magnitude and radicand
`default_nettype none
module ssp_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               valid_in,
    input  wire logic [15:0]        pos,
    input  wire logic [15:0]        pitch,
    output logic                    valid_out,
    output ssp_pkg::cor_t           data_out
);
    logic [4:0]         v_reg;
    logic [44:0]        rprod_reg;
    logic signed [32:0] p_reg;
    logic [1:0]         q1_reg, q2_reg, q3_reg, q4_reg, q5_reg;
    logic signed [33:0] a2_reg, a3_reg, a4_reg, a5_reg;
    logic [30:0]        pm_reg;
    logic               n2_reg, n3_reg, n4_reg, n5_reg;
    logic [61:0]        uprod_reg;
    logic [31:0]        um4_reg, um5_reg;
    logic [63:0]        sq_reg;

    logic signed [16:0] pofs;
    logic signed [32:0] p_next;
    logic [44:0]        rprod_next;
    logic [32:0]        pabs;
    logic [62:0]        urnd;

    always_comb
    begin
        pofs       = $signed({1'b0, pos}) - 17'sd16384;
        p_next     = 33'($signed(pitch)) * 33'(pofs);
        rprod_next = 45'(pos[11:0]) * 45'(ssp_pkg::TWO_PI_Q30);
        pabs       = p_reg[32] ? 33'(-p_reg) : 33'(p_reg);
        urnd       = 63'(uprod_reg) + 63'(64'd1 << 29);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rprod_reg <= rprod_next;
            p_reg     <= p_next;
            q1_reg    <= pos[13:12];
            // angle in the quadrant, radians q30
            a2_reg    <= 34'((rprod_reg + 45'd8192) >> 14);
            pm_reg    <= pabs[30:0];
            n2_reg    <= !p_reg[32] && (p_reg != '0);
            q2_reg    <= q1_reg;
            uprod_reg <= 62'(pm_reg) * 62'(ssp_pkg::TWO_PI_Q28);
            a3_reg    <= a2_reg;
            n3_reg    <= n2_reg;
            q3_reg    <= q2_reg;
            um4_reg   <= urnd[61:30];
            a4_reg    <= a3_reg;
            n4_reg    <= n3_reg;
            q4_reg    <= q3_reg;
            sq_reg    <= 64'(um4_reg) * 64'(um4_reg) + (64'd1 << 48);
            um5_reg   <= um4_reg;
            a5_reg    <= a4_reg;
            n5_reg    <= n4_reg;
            q5_reg    <= q4_reg;
        end
    end

    assign valid_out          = v_reg[4];
    assign data_out.ang       = a5_reg;
    assign data_out.cx        = ssp_pkg::CORDIC_K;
    assign data_out.cy        = '0;
    assign data_out.side.quad = q5_reg;
    assign data_out.side.um   = um5_reg;
    assign data_out.side.sq   = sq_reg;
    assign data_out.side.pneg = n5_reg;
endmodule
`default_nettype wire

[hw/rtl/ssp_cordic_cell.sv]
// one rotation step of the sine/cosine chain
`default_nettype none
module ssp_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               valid_in,
    input  wire ssp_pkg::cor_t      data_in,
    output logic                    valid_out,
    output ssp_pkg::cor_t           data_out
);
    logic          valid_reg;
    ssp_pkg::cor_t data_reg, data_next;
    logic signed [32:0] dx, dy;

    always_comb
    begin
        dx        = data_in.cx >>> STEP;
        dy        = data_in.cy >>> STEP;
        data_next = data_in;
        if (data_in.ang >= 0)
        begin
            data_next.cx  = data_in.cx - dy;
            data_next.cy  = data_in.cy + dx;
            data_next.ang = data_in.ang - ssp_pkg::atan_q30(STEP);
        end
        else
        begin
            data_next.cx  = data_in.cx + dy;
            data_next.cy  = data_in.cy - dx;
            data_next.ang = data_in.ang + ssp_pkg::atan_q30(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
endmodule
`default_nettype wire

[hw/rtl/ssp_sqrt_cell.sv]
// one result bit of the digit-by-digit square root
`default_nettype none
module ssp_sqrt_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               valid_in,
    input  wire ssp_pkg::sq_t       data_in,
    output logic                    valid_out,
    output ssp_pkg::sq_t            data_out
);
    logic         valid_reg;
    ssp_pkg::sq_t data_reg, data_next;
    logic [35:0]  t;
    logic [35:0]  trial;

    always_comb
    begin
        t         = {data_in.rem, data_in.n[63:62]};
        trial     = 36'({data_in.root, 2'b01});
        data_next = data_in;
        data_next.n = {data_in.n[61:0], 2'b00};
        if (t >= trial)
        begin
            data_next.rem  = 34'(t - trial);
            data_next.root = {data_in.root[30:0], 1'b1};
        end
        else
        begin
            data_next.rem  = t[33:0];
            data_next.root = {data_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
endmodule
`default_nettype wire

[hw/rtl/ssp_div_cell.sv]
// one quotient bit of the three restoring dividers
`default_nettype none
module ssp_div_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               valid_in,
    input  wire ssp_pkg::dv_t       data_in,
    output logic                    valid_out,
    output ssp_pkg::dv_t            data_out
);
    logic         valid_reg;
    ssp_pkg::dv_t data_reg, data_next;
    logic [32:0]  t [3];
    logic [2:0]   qb;

    always_comb
    begin
        data_next = data_in;
        for (int l = 0; l < 3; l++)
        begin
            t[l] = {data_in.rem[l], data_in.qn[l][16]};
            qb[l] = t[l] >= {1'b0, data_in.den};
            data_next.rem[l] = qb[l] ? 32'(t[l] - {1'b0, data_in.den}) : t[l][31:0];
            // numerator bits shift out the top while quotient bits shift in
            data_next.qn[l] = {data_in.qn[l][15:0], qb[l]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
endmodule
`default_nettype wire

[hw/rtl/spherical_spiral_point_generator_top.sv]
// top level: spherical spiral point generator pipeline
// Takes one position sample per clock and returns one (x, y, z) point per sample,
// passing it through 5 front stages, a chain of 20 CORDIC cells,
// 32 square-root cells, 17 divider cells and the output register. Every stage
// moves together; while the output register holds a result that is not taken,
// the whole chain holds and s_tready is low. The pitch register should be
// written only while no sample is in flight.
`default_nettype none
module spherical_spiral_point_generator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // spiral_pitch
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,       // position
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata        // coord_x, coord_y, coord_z
);
    localparam int NC = ssp_pkg::CORDIC_STEPS;
    localparam int NS = ssp_pkg::SQRT_STEPS;
    localparam int ND = ssp_pkg::DIV_STEPS;

    logic        pitch_reg;
    logic [15:0] pitch_val_reg;
    logic        en;
    logic        m_valid_reg;
    logic [47:0] m_data_reg;

    logic          cv [NC+1];
    ssp_pkg::cor_t cd [NC+1];
    logic          sv [NS+1];
    ssp_pkg::sq_t  sd [NS+1];
    logic          dvv [ND+1];
    ssp_pkg::dv_t  dd [ND+1];

    logic signed [33:0] cosv, sinv;
    logic [31:0] den;
    logic [47:0] nx, ny, nz;
    logic [15:0] ox, oy, oz;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg     <= 1'b0;
            pitch_val_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            pitch_reg     <= 1'b1;
            pitch_val_reg <= cfg_wr_data;
        end
    end

    ssp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (s_tvalid && s_tready),
        .pos       (s_tdata),
        .pitch     (pitch_reg ? pitch_val_reg : 16'd0),
        .valid_out (cv[0]),
        .data_out  (cd[0])
    );

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        ssp_cordic_cell #(.STEP(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (cv[i]),
            .data_in   (cd[i]),
            .valid_out (cv[i+1]),
            .data_out  (cd[i+1])
        );
    end

    // quadrant rotation by multiples of pi/2
    always_comb
    begin
        case (cd[NC].side.quad)
            2'd0:    begin cosv = 34'(cd[NC].cx);  sinv = 34'(cd[NC].cy);  end
            2'd1:    begin cosv = -34'(cd[NC].cy); sinv = 34'(cd[NC].cx);  end
            2'd2:    begin cosv = -34'(cd[NC].cx); sinv = -34'(cd[NC].cy); end
            default: begin cosv = 34'(cd[NC].cy);  sinv = -34'(cd[NC].cx); end
        endcase
        sd[0].rem  = '0;
        sd[0].root = '0;
        sd[0].n    = cd[NC].side.sq;
        sd[0].xneg = cosv[33];
        sd[0].yneg = sinv[33];
        sd[0].xmag = cosv[33] ? 33'(-cosv) : 33'(cosv);
        sd[0].ymag = sinv[33] ? 33'(-sinv) : 33'(sinv);
        sd[0].zneg = cd[NC].side.pneg;
        sd[0].um   = cd[NC].side.um;
    end
    assign sv[0] = cv[NC];

    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        ssp_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sv[i]),
            .data_in   (sd[i]),
            .valid_out (sv[i+1]),
            .data_out  (sd[i+1])
        );
    end

    // rounded numerators; each quotient stays below 2^17
    always_comb
    begin
        den = sd[NS].root;
        nx  = {6'd0, sd[NS].xmag, 9'd0} + 48'(den >> 1);
        ny  = {6'd0, sd[NS].ymag, 9'd0} + 48'(den >> 1);
        nz  = {1'b0, sd[NS].um, 15'd0} + 48'(den >> 1);
        dd[0].den    = den;
        dd[0].rem[0] = 32'(nx[47:17]);
        dd[0].rem[1] = 32'(ny[47:17]);
        dd[0].rem[2] = 32'(nz[47:17]);
        dd[0].qn[0]  = nx[16:0];
        dd[0].qn[1]  = ny[16:0];
        dd[0].qn[2]  = nz[16:0];
        dd[0].neg    = {sd[NS].zneg, sd[NS].yneg, sd[NS].xneg};
    end
    assign dvv[0] = sv[NS];

    for (genvar i = 0; i < ND; i++)
    begin : g_div
        ssp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dvv[i]),
            .data_in   (dd[i]),
            .valid_out (dvv[i+1]),
            .data_out  (dd[i+1])
        );
    end

    function automatic logic [15:0] sat_q15(input logic [16:0] mag, input logic neg);
        logic [16:0] m;
        if (neg)
        begin
            m = (mag > 17'd32768) ? 17'd32768 : mag;
            return 16'(17'd0 - m);
        end
        m = (mag > 17'd32767) ? 17'd32767 : mag;
        return m[15:0];
    endfunction

    assign ox = sat_q15(dd[ND].qn[0], dd[ND].neg[0]);
    assign oy = sat_q15(dd[ND].qn[1], dd[ND].neg[1]);
    assign oz = sat_q15(dd[ND].qn[2], dd[ND].neg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= dvv[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= {oz, oy, ox};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
`default_nettype wire

[hw/rtl/ssp_checker.sv]
// port-level checks of the spherical spiral generator, bound to the top level
`default_nettype none
module ssp_port_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);
    // a waiting result holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side is ready exactly when the pipeline can advance
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // a new result only appears after the pipeline advanced
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("result appeared while pipeline held");
endmodule

bind spherical_spiral_point_generator_top ssp_port_checker u_ssp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
